@@ design/mba_pkg.sv @@
// ----------------------------------------------------------------------------
// mba_pkg
// Shared types and constants of the multichannel block averager.
// ----------------------------------------------------------------------------
package mba_pkg;

    localparam int CHANNELS_DEF      = 8;
    localparam int FRACTION_BITS_DEF = 6;

    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 26;
    localparam int COUNT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int AVG_W       = 16;
    localparam int CHAN_OUT_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MODE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS          = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SAMPLES_PER_WINDOW_RST = 16'd16;
    localparam logic [CFG_DATA_W-1:0] WINDOW_MS_RST          = 16'd100;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ design/mba_state_mem.sv @@
// ----------------------------------------------------------------------------
// mba_state_mem
// Per-channel window state: sum, count and start time, one entry per
// channel, with registered read data and a valid bit per entry.
// ----------------------------------------------------------------------------
module mba_state_mem #(
    parameter int CHANNELS = mba_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output mba_pkg::entry_t    rd_entry,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  mba_pkg::entry_t    wr_entry
);

    mba_pkg::entry_t       mem [CHANNELS];
    logic [CHANNELS-1:0]   valid_reg;
    mba_pkg::entry_t       rd_data_reg;
    logic                  rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

@@ design/mba_divider.sv @@
// ----------------------------------------------------------------------------
// mba_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mba_divider #(
    parameter int DIVIDEND_W = mba_pkg::SUM_W + mba_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIVIDEND_W-1:0]        dividend,
    input  logic [mba_pkg::COUNT_W-1:0]  divisor,
    output mba_pkg::div_status_t         status,
    output logic [DIVIDEND_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam int REM_W = mba_pkg::COUNT_W + 1;

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              step_reg;
    logic [DIVIDEND_W-1:0]         dvd_reg;
    logic [mba_pkg::COUNT_W-1:0]   rem_reg;
    logic [mba_pkg::COUNT_W-1:0]   dvs_reg;
    logic [REM_W-1:0]              trial;
    logic [REM_W-1:0]              diff;
    logic                          qbit;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], qbit};
            rem_reg <= qbit ? diff[mba_pkg::COUNT_W-1:0] : trial[mba_pkg::COUNT_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

@@ design/multichannel_block_averager.sv @@
// ----------------------------------------------------------------------------
// multichannel_block_averager
// A call that does not close a window passes from S_IDLE through S_EVAL; the idle
// slot only returns the pointer to channel zero. A closing call with samples runs
// S_EVAL, S_DIV (the bit-serial divider) and S_OUT; an empty window skips S_DIV.
// The per-channel state sits in one memory with a registered read port.
// Reset clears the pointer, state, configuration and output valid, and invalidates all window state at once.
// ----------------------------------------------------------------------------
module multichannel_block_averager #(
    parameter int CHANNELS      = mba_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = mba_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mba_pkg::SAMPLE_W-1:0]      sample,
    input  logic [mba_pkg::TIME_W-1:0]        now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mba_pkg::CHAN_OUT_W-1:0]    channel,
    output logic [mba_pkg::AVG_W-1:0]         average,
    output logic                              empty_window,
    input  logic                              cfg_we,
    input  logic [mba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PTR_W      = $clog2(CHANNELS + 1);
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIVIDEND_W = mba_pkg::SUM_W + FRACTION_BITS;

    mba_pkg::state_t                   state_reg;
    mba_pkg::state_t                   state_next;
    logic [PTR_W-1:0]                  ptr_reg;
    logic [IDX_W-1:0]                  ch_reg;
    logic [mba_pkg::SAMPLE_W-1:0]      sample_reg;
    logic [mba_pkg::TIME_W-1:0]        now_reg;

    logic                              mode_reg;
    logic [mba_pkg::COUNT_W-1:0]       spw_reg;
    logic [mba_pkg::CFG_DATA_W-1:0]    wms_reg;

    logic                              res_empty_reg;
    logic [mba_pkg::AVG_W-1:0]         res_avg_reg;
    logic                              out_valid_reg;
    logic [mba_pkg::CHAN_OUT_W-1:0]    channel_reg;
    logic [mba_pkg::AVG_W-1:0]         average_reg;
    logic                              empty_reg;

    logic                              accept;
    logic                              idle_slot;
    logic                              rd_en;
    mba_pkg::entry_t                   rd_entry;
    logic                              wr_en;
    mba_pkg::entry_t                   wr_entry;
    logic                              close;
    logic [mba_pkg::TIME_W-1:0]        elapsed;
    logic [mba_pkg::SUM_W:0]           sum_add;
    logic                              div_start;
    mba_pkg::div_status_t              div_status;
    logic [DIVIDEND_W-1:0]             quotient;
    logic [mba_pkg::AVG_W-1:0]         quot_sat;
    logic                              load_out;

    assign in_ready  = (state_reg == mba_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign idle_slot = (ptr_reg == PTR_W'(CHANNELS));
    assign rd_en     = accept && !idle_slot;

    mba_state_mem #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (ptr_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (ch_reg),
        .wr_entry (wr_entry)
    );

    mba_divider #(
        .DIVIDEND_W (DIVIDEND_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIVIDEND_W'(rd_entry.sum) << FRACTION_BITS),
        .divisor  (rd_entry.count),
        .status   (div_status),
        .quotient (quotient)
    );

    assign quot_sat = (|quotient[DIVIDEND_W-1:mba_pkg::AVG_W]) ? mba_pkg::AVG_MAX
                                                              : quotient[mba_pkg::AVG_W-1:0];

    always_comb
    begin
        elapsed = now_reg - rd_entry.start;
        sum_add = {1'b0, rd_entry.sum} + (mba_pkg::SUM_W + 1)'(sample_reg);
        if (mode_reg)
        begin
            close = (elapsed > mba_pkg::TIME_W'(wms_reg));
        end
        else
        begin
            close = (rd_entry.count >= spw_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        wr_entry   = rd_entry;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            mba_pkg::S_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = mba_pkg::S_EVAL;
                end
            end
            mba_pkg::S_EVAL:
            begin
                wr_en = 1'b1;
                if (close)
                begin
                    wr_entry.sum   = '0;
                    wr_entry.count = '0;
                    if (mode_reg)
                    begin
                        wr_entry.start = now_reg;
                    end
                    if (rd_entry.count == '0)
                    begin
                        state_next = mba_pkg::S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = mba_pkg::S_DIV;
                    end
                end
                else
                begin
                    if (rd_entry.count < mba_pkg::COUNT_MAX)
                    begin
                        wr_entry.sum = sum_add[mba_pkg::SUM_W] ? mba_pkg::SUM_MAX
                                                               : sum_add[mba_pkg::SUM_W-1:0];
                        wr_entry.count = rd_entry.count + 1'b1;
                    end
                    state_next = mba_pkg::S_IDLE;
                end
            end
            mba_pkg::S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = mba_pkg::S_OUT;
                end
            end
            mba_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = mba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mba_pkg::S_IDLE;
            ptr_reg       <= '0;
            mode_reg      <= 1'b0;
            spw_reg       <= mba_pkg::SAMPLES_PER_WINDOW_RST;
            wms_reg       <= mba_pkg::WINDOW_MS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ptr_reg <= idle_slot ? '0 : ptr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mba_pkg::CFG_WINDOW_MODE:        mode_reg <= cfg_data[0];
                    mba_pkg::CFG_SAMPLES_PER_WINDOW: spw_reg  <= cfg_data;
                    mba_pkg::CFG_WINDOW_MS:          wms_reg  <= cfg_data;
                    default:                         mode_reg <= mode_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ch_reg     <= ptr_reg[IDX_W-1:0];
            sample_reg <= sample;
            now_reg    <= now_ms;
        end
        if (state_reg == mba_pkg::S_EVAL)
        begin
            res_empty_reg <= 1'b1;
            res_avg_reg   <= '0;
        end
        else if (state_reg == mba_pkg::S_DIV && div_status.done)
        begin
            res_empty_reg <= 1'b0;
            res_avg_reg   <= quot_sat;
        end
        if (load_out)
        begin
            channel_reg <= mba_pkg::CHAN_OUT_W'(ch_reg);
            average_reg <= res_avg_reg;
            empty_reg   <= res_empty_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign channel      = channel_reg;
    assign average      = average_reg;
    assign empty_window = empty_reg;

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == mba_pkg::S_DIV))
        else $error("Divider busy outside the divide state.");

    a_idle_slot_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && idle_slot) |=> (ptr_reg == '0 && state_reg == mba_pkg::S_IDLE))
        else $error("Idle slot did not return the pointer to channel zero.");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_window) |-> (average == '0))
        else $error("Empty window transaction carries a nonzero average.");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mba_pkg::S_OUT))
        else $error("Result appeared without passing the output state.");

endmodule
